/* sv/ges_pkg.sv */
// Shared types and constants for the graph adjacency edge store.
// No dependencies; every other file but ges_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ges_pkg;

  // Node count the store is built for.
  localparam int MAX_NODES = 64;
  // Memory address width for one node or one matrix row.
  localparam int NODE_AW   = $clog2(MAX_NODES);
  // Counter width: holds 0..MAX_NODES.
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  // Edge total width: holds 0..MAX_NODES*MAX_NODES.
  localparam int EDGE_W    = $clog2(MAX_NODES * MAX_NODES + 1);

  // Fixed field widths of the channels.
  localparam int OP_W      = 2;
  localparam int IDX_W     = 6;
  localparam int NUM_W     = 7;

  localparam logic [NUM_W-1:0] NUM_NODES_RST = NUM_W'(64);
  localparam logic [CNT_W-1:0] NODE_LIMIT    = CNT_W'(MAX_NODES);

  // Operation codes carried in the op field.
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WRB
  } ges_state_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic accept;  // input beat taken this cycle
    logic calc;    // read data valid: compute, write source node
    logic wrb;     // write destination node
    logic finish;  // move the result into the output register
  } ges_ctl_t;

  // One entry of the node count memory.
  typedef struct packed {
    logic [CNT_W-1:0] out_deg;
    logic [CNT_W-1:0] in_deg;
    logic [CNT_W-1:0] nbr;
  } node_cnt_t;

  localparam int NODE_W = $bits(node_cnt_t);

endpackage : ges_pkg

`default_nettype wire

/* sv/ges_if.sv */
// Channel interfaces of the edge store: item input, result output, configuration.
// Depends on ges_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ges_in_if import ges_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] node_from;
  logic [IDX_W-1:0] node_to;

  modport source (output valid, op, node_from, node_to, input ready);
  modport sink   (input valid, op, node_from, node_to, output ready);
endinterface : ges_in_if

interface ges_out_if import ges_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              changed;
  logic              bad_index;
  logic [NUM_W-1:0]  out_degree_from;
  logic [NUM_W-1:0]  in_degree_to;
  logic [NUM_W-1:0]  neighbours_from;
  logic [NUM_W-1:0]  neighbours_to;
  logic [EDGE_W-1:0] edge_total;

  modport source (output valid, changed, bad_index, out_degree_from, in_degree_to,
                  neighbours_from, neighbours_to, edge_total, input ready);
  modport sink   (input valid, changed, bad_index, out_degree_from, in_degree_to,
                  neighbours_from, neighbours_to, edge_total, output ready);
endinterface : ges_out_if

interface ges_cfg_if import ges_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface : ges_cfg_if

`default_nettype wire

/* sv/graph_adjacency_edge_store.sv */
// Directed graph store over a bit adjacency matrix with per-node degree counts.
// Idle takes the input beat, the memory reads are registered, compute forms the
// result and write-back moves it into the output register. A new item is taken
// only after write-back, paced by the two writes per item into the single write
// port of the node count memory plus the read; a waiting result stalls write-back.
// Reset and clear: per-row valid flags zero the matrix and counts at once, no sweep.
`timescale 1ns / 1ps
`default_nettype none

module graph_adjacency_edge_store import ges_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ges_in_if.sink     in_bus,
  ges_out_if.source  out_bus,
  ges_cfg_if.sink    cfg_bus
);

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  ges_ctl_t              ctl;
  logic                  out_busy;

  logic [NUM_W-1:0]      num_nodes_r;
  logic [CNT_W-1:0]      limit;

  logic [OP_W-1:0]       op_r;
  logic [NODE_AW-1:0]    a_r, b_r;
  logic                  a_ok_r, b_ok_r;

  logic [MAX_NODES-1:0]  adj_vld_r, node_vld_r;
  logic [EDGE_W-1:0]     edge_cnt_r, edge_cnt_nxt;

  logic [MAX_NODES-1:0]  adj_q0, adj_q1;
  node_cnt_t             node_q0, node_q1;

  logic [MAX_NODES-1:0]  row_a, row_b, row_a_new;
  node_cnt_t             node_a, node_b, node_a_new, node_b_new, node_self;
  node_cnt_t             node_b_new_r;
  logic                  bit_ab, bit_ba, self_loop;
  logic                  do_add, do_rem, do_clr, chg, nbr_chg;
  logic                  chg_r;

  logic                  adj_we, node_we;
  logic [NODE_AW-1:0]    node_waddr;
  node_cnt_t             node_wdata;

  // Result held between compute and hand-off.
  logic                  res_changed_r, res_bad_r;
  logic [NUM_W-1:0]      res_outd_r, res_ind_r, res_nbf_r, res_nbt_r;
  logic [EDGE_W-1:0]     res_edge_r;

  logic                  out_valid_r;
  logic                  out_changed_r, out_bad_r;
  logic [NUM_W-1:0]      out_outd_r, out_ind_r, out_nbf_r, out_nbt_r;
  logic [EDGE_W-1:0]     out_edge_r;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign out_busy = out_valid_r && !out_bus.ready;

  ges_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .out_busy (out_busy),
    .in_ready (in_bus.ready),
    .ctl      (ctl)
  );

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_nodes_r <= NUM_NODES_RST;
    end else if (cfg_bus.valid) begin
      num_nodes_r <= cfg_bus.data;
    end
  end

  // Saturate the node limit at the built size.
  assign limit = (CNT_W'(num_nodes_r) > NODE_LIMIT) ? NODE_LIMIT : CNT_W'(num_nodes_r);

  // ---------------------------------------------------------------------------
  // Capture the input beat
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op_r   <= in_bus.op;
      a_r    <= in_bus.node_from[NODE_AW-1:0];
      b_r    <= in_bus.node_to[NODE_AW-1:0];
      a_ok_r <= CNT_W'(in_bus.node_from) < limit;
      b_ok_r <= CNT_W'(in_bus.node_to) < limit;
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: matrix rows and per-node counts, both read at source and destination
  // ---------------------------------------------------------------------------
  ges_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
    .clk    (clk),
    .we     (adj_we),
    .waddr  (a_r),
    .wdata  (row_a_new),
    .raddr0 (in_bus.node_from[NODE_AW-1:0]),
    .raddr1 (in_bus.node_to[NODE_AW-1:0]),
    .rdata0 (adj_q0),
    .rdata1 (adj_q1)
  );

  ges_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_ram (
    .clk    (clk),
    .we     (node_we),
    .waddr  (node_waddr),
    .wdata  (node_wdata),
    .raddr0 (in_bus.node_from[NODE_AW-1:0]),
    .raddr1 (in_bus.node_to[NODE_AW-1:0]),
    .rdata0 (node_q0),
    .rdata1 (node_q1)
  );

  // ---------------------------------------------------------------------------
  // Compute: decode, update row and counts
  // ---------------------------------------------------------------------------
  always_comb begin
    // Entries never written since reset or clear read as zero.
    row_a  = adj_vld_r[a_r]  ? adj_q0  : '0;
    row_b  = adj_vld_r[b_r]  ? adj_q1  : '0;
    node_a = node_vld_r[a_r] ? node_q0 : '0;
    node_b = node_vld_r[b_r] ? node_q1 : '0;

    bit_ab    = row_a[b_r];
    bit_ba    = row_b[a_r];
    self_loop = (a_r == b_r);

    do_add = 1'b0;
    do_rem = 1'b0;
    do_clr = 1'b0;
    unique case (op_r)
      OP_ADD:    do_add = a_ok_r && b_ok_r && !bit_ab;
      OP_REMOVE: do_rem = a_ok_r && b_ok_r && bit_ab;
      OP_CLEAR:  do_clr = 1'b1;
      default:   ;
    endcase
    chg     = do_add || do_rem;
    nbr_chg = chg && !self_loop && !bit_ba;

    row_a_new      = row_a;
    row_a_new[b_r] = do_add;

    node_a_new = node_a;
    node_b_new = node_b;
    if (do_add) begin
      node_a_new.out_deg = node_a.out_deg + 1'b1;
      node_b_new.in_deg  = node_b.in_deg + 1'b1;
    end else if (do_rem) begin
      node_a_new.out_deg = node_a.out_deg - 1'b1;
      node_b_new.in_deg  = node_b.in_deg - 1'b1;
    end
    if (nbr_chg && do_add) begin
      node_a_new.nbr = node_a.nbr + 1'b1;
      node_b_new.nbr = node_b.nbr + 1'b1;
    end else if (nbr_chg) begin
      node_a_new.nbr = node_a.nbr - 1'b1;
      node_b_new.nbr = node_b.nbr - 1'b1;
    end

    // Self-loop: both degrees sit in one entry.
    node_self         = node_a_new;
    node_self.in_deg  = node_b_new.in_deg;

    if (do_clr) begin
      edge_cnt_nxt = '0;
    end else if (do_add) begin
      edge_cnt_nxt = edge_cnt_r + 1'b1;
    end else if (do_rem) begin
      edge_cnt_nxt = edge_cnt_r - 1'b1;
    end else begin
      edge_cnt_nxt = edge_cnt_r;
    end
  end

  // Write the source node while computing, the destination node in the cycle after.
  assign adj_we     = ctl.calc && chg;
  assign node_we    = ctl.calc ? chg : (ctl.wrb && chg_r && (a_r != b_r));
  assign node_waddr = ctl.calc ? a_r : b_r;
  assign node_wdata = ctl.calc ? (self_loop ? node_self : node_a_new) : node_b_new_r;

  // ---------------------------------------------------------------------------
  // Valid flags and edge total
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_vld_r  <= '0;
      node_vld_r <= '0;
      edge_cnt_r <= '0;
    end else begin
      if (ctl.calc) begin
        edge_cnt_r <= edge_cnt_nxt;
      end
      if (ctl.calc && do_clr) begin
        adj_vld_r  <= '0;
        node_vld_r <= '0;
      end else begin
        if (adj_we) begin
          adj_vld_r[a_r] <= 1'b1;
        end
        if (node_we) begin
          node_vld_r[node_waddr] <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Hold the result until the output register is free
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      chg_r         <= chg;
      node_b_new_r  <= node_b_new;
      res_changed_r <= do_clr ? (edge_cnt_r != '0) : chg;
      res_bad_r     <= (op_r == OP_ADD || op_r == OP_REMOVE) && !(a_ok_r && b_ok_r);
      res_outd_r    <= (a_ok_r && !do_clr) ? NUM_W'(node_a_new.out_deg) : '0;
      res_ind_r     <= (b_ok_r && !do_clr) ? NUM_W'(node_b_new.in_deg)  : '0;
      res_nbf_r     <= (a_ok_r && !do_clr) ? NUM_W'(node_a_new.nbr)     : '0;
      res_nbt_r     <= (b_ok_r && !do_clr) ? NUM_W'(node_b_new.nbr)     : '0;
      res_edge_r    <= edge_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_changed_r <= res_changed_r;
      out_bad_r     <= res_bad_r;
      out_outd_r    <= res_outd_r;
      out_ind_r     <= res_ind_r;
      out_nbf_r     <= res_nbf_r;
      out_nbt_r     <= res_nbt_r;
      out_edge_r    <= res_edge_r;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.changed         = out_changed_r;
  assign out_bus.bad_index       = out_bad_r;
  assign out_bus.out_degree_from = out_outd_r;
  assign out_bus.in_degree_to    = out_ind_r;
  assign out_bus.neighbours_from = out_nbf_r;
  assign out_bus.neighbours_to   = out_nbt_r;
  assign out_bus.edge_total      = out_edge_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A rejected item never reports a change.
  a_bad_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> !(out_bus.changed && out_bus.bad_index))
    else $error("bad_index beat reports a change");

  // A clear leaves the edge total at zero.
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.calc && op_r == OP_CLEAR) |=> (edge_cnt_r == '0))
    else $error("edge total not zero after clear");

  // The destination-node write never targets the source node of a self-loop.
  a_wrb_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.wrb && node_we) |-> (a_r != b_r))
    else $error("second node write on a self-loop");

  // A finished result never overwrites one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |-> !(out_valid_r && !out_bus.ready))
    else $error("result register overwritten");

endmodule : graph_adjacency_edge_store

`default_nettype wire

/* sv/ges_ram.sv */
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ges_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register both read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule : ges_ram

`default_nettype wire

/* sv/ges_ctrl.sv */
// Item sequencer of the edge store: accept, compute, second write, hand-off.
// Depends on ges_pkg for the state and strobe types.
`timescale 1ns / 1ps
`default_nettype none

module ges_ctrl import ges_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic out_busy,
  output logic      in_ready,
  output ges_ctl_t  ctl
);

  ges_state_t state_r, state_nxt;

  // Hold the state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance one item through read, compute and write-back.
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    ctl        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_nxt  = ST_CALC;
        end
      end
      ST_CALC: begin
        ctl.calc  = 1'b1;
        state_nxt = ST_WRB;
      end
      ST_WRB: begin
        ctl.wrb = 1'b1;
        // Stall here while the previous result is still waiting.
        if (!out_busy) begin
          ctl.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule : ges_ctrl

`default_nettype wire

/* sim/graph_adjacency_edge_store_checker.sv */
// Scoreboard for the graph edge store: watches the item, result and node count channels.
// Keeps its own copy of the adjacency matrix and counters and checks every result beat.
// Depends on ges_pkg and the channel interfaces in ges_if.sv.
`timescale 1ns / 1ps

module graph_adjacency_edge_store_checker import ges_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  ges_in_if         in_mon,
  ges_out_if        out_mon,
  ges_cfg_if        cfg_mon,
  output int        fail_count,
  output int        pending
);

  typedef struct {
    int                item_no;
    logic              changed;
    logic              bad_index;
    logic [NUM_W-1:0]  out_degree_from;
    logic [NUM_W-1:0]  in_degree_to;
    logic [NUM_W-1:0]  neighbours_from;
    logic [NUM_W-1:0]  neighbours_to;
    logic [EDGE_W-1:0] edge_total;
  } edge_result_t;

  // Shadow graph: one row of bits per source node, counters kept wide.
  bit [MAX_NODES-1:0] adj_rows [MAX_NODES];
  int unsigned        out_deg [MAX_NODES];
  int unsigned        in_deg [MAX_NODES];
  int unsigned        nbr_cnt [MAX_NODES];
  int unsigned        edge_cnt;
  logic [NUM_W-1:0]   node_count;

  edge_result_t       expected_q [$];
  int                 errors = 0;
  int                 items_seen = 0;

  task automatic report_fail(string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void wipe_graph();
    for (int n = 0; n < MAX_NODES; n++) begin
      adj_rows[n] = '0;
      out_deg[n]  = 0;
      in_deg[n]   = 0;
      nbr_cnt[n]  = 0;
    end
    edge_cnt = 0;
  endfunction

  // Apply one item to the shadow graph and return the result it should produce.
  function automatic edge_result_t apply_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] src,
                                              logic [IDX_W-1:0] dst);
    edge_result_t r;
    int unsigned  lim;
    bit           src_ok;
    bit           dst_ok;
    lim         = (node_count > MAX_NODES) ? MAX_NODES : node_count;
    src_ok      = src < lim;
    dst_ok      = dst < lim;
    r.changed   = 1'b0;
    r.bad_index = 1'b0;
    if (op == OP_CLEAR) begin
      r.changed = edge_cnt != 0;
      wipe_graph();
    end else if (op == OP_ADD || op == OP_REMOVE) begin
      if (!src_ok || !dst_ok) begin
        r.bad_index = 1'b1;
      end else if (op == OP_ADD && !adj_rows[src][dst]) begin
        adj_rows[src][dst] = 1'b1;
        out_deg[src]++;
        in_deg[dst]++;
        edge_cnt++;
        // a new pair of neighbours only if the reverse edge was not already linking them
        if (src != dst && !adj_rows[dst][src]) begin
          nbr_cnt[src]++;
          nbr_cnt[dst]++;
        end
        r.changed = 1'b1;
      end else if (op == OP_REMOVE && adj_rows[src][dst]) begin
        adj_rows[src][dst] = 1'b0;
        out_deg[src]--;
        in_deg[dst]--;
        edge_cnt--;
        if (src != dst && !adj_rows[dst][src]) begin
          nbr_cnt[src]--;
          nbr_cnt[dst]--;
        end
        r.changed = 1'b1;
      end
    end
    // per-node fields of an index out of range read as zero, whatever the op
    r.out_degree_from = src_ok ? NUM_W'(out_deg[src]) : '0;
    r.in_degree_to    = dst_ok ? NUM_W'(in_deg[dst]) : '0;
    r.neighbours_from = src_ok ? NUM_W'(nbr_cnt[src]) : '0;
    r.neighbours_to   = dst_ok ? NUM_W'(nbr_cnt[dst]) : '0;
    r.edge_total      = EDGE_W'(edge_cnt);
    return r;
  endfunction

  task automatic check_field(int item_no, string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_fail($sformatf("item %0d %s: got %0d, want %0d", item_no, name, got, want));
  endtask

  always @(posedge clk) begin : watch
    edge_result_t want;
    edge_result_t next;
    if (!rst_n) begin
      wipe_graph();
      node_count = NUM_NODES_RST;
      expected_q.delete();
    end else begin
      // take node count writes first: they only happen with the store idle
      if (cfg_mon.valid && cfg_mon.ready) node_count = cfg_mon.data;

      // check the result beat against the oldest outstanding item
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_fail("result beat with no item outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field(want.item_no, "changed", 16'(out_mon.changed), 16'(want.changed));
          check_field(want.item_no, "bad_index", 16'(out_mon.bad_index), 16'(want.bad_index));
          check_field(want.item_no, "out_degree_from", 16'(out_mon.out_degree_from),
                      16'(want.out_degree_from));
          check_field(want.item_no, "in_degree_to", 16'(out_mon.in_degree_to),
                      16'(want.in_degree_to));
          check_field(want.item_no, "neighbours_from", 16'(out_mon.neighbours_from),
                      16'(want.neighbours_from));
          check_field(want.item_no, "neighbours_to", 16'(out_mon.neighbours_to),
                      16'(want.neighbours_to));
          check_field(want.item_no, "edge_total", 16'(out_mon.edge_total),
                      16'(want.edge_total));
        end
      end

      // predict the item beat and queue it behind the others
      if (in_mon.valid && in_mon.ready) begin
        next = apply_item(in_mon.op, in_mon.node_from, in_mon.node_to);
        next.item_no = items_seen;
        items_seen++;
        expected_q = {expected_q, next};
      end
    end
    pending    <= expected_q.size();
    fail_count <= errors;
  end

endmodule : graph_adjacency_edge_store_checker

/* sim/graph_adjacency_edge_store_test.sv */
// Top of the edge store testbench: clock, reset, item and node count stimulus, result sink.
// Depends on ges_pkg, ges_if.sv, the store itself and graph_adjacency_edge_store_checker.
`timescale 1ns / 1ps

module graph_adjacency_edge_store_test;
  import ges_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LONG_HOLD = 150;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;

  bit   tx_idling = 1'b0;
  bit   rx_idling = 1'b0;
  int   holds_asked = 0;
  int   holds_taken = 0;

  ges_in_if  in_bus ();
  ges_out_if out_bus ();
  ges_cfg_if cfg_bus ();

  graph_adjacency_edge_store u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  graph_adjacency_edge_store_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_mon    (cfg_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(12, 40))
                                       : int'($urandom_range(1, 3));
  endfunction

  // Offer one item, hold it until taken, then maybe idle for a while.
  task automatic send_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] src,
                           logic [IDX_W-1:0] dst);
    int gap;
    in_bus.valid     <= 1'b1;
    in_bus.op        <= op;
    in_bus.node_from <= src;
    in_bus.node_to   <= dst;
    do @(posedge clk); while (!in_bus.ready);
    gap = (tx_idling && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random items over nodes 0..span-1, with self-loops and some full-range noise.
  task automatic send_random(int count, int span);
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] dst;
    int               pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      src  = IDX_W'($urandom_range(0, span - 1));
      dst  = ($urandom_range(0, 9) == 0) ? src : IDX_W'($urandom_range(0, span - 1));
      if (pick < 50) op = OP_ADD;
      else if (pick < 85) op = OP_REMOVE;
      else if (pick < 87) op = OP_CLEAR;
      else if (pick < 90) op = OP_UNUSED;
      else begin
        op  = pick[0] ? OP_ADD : OP_REMOVE;
        src = IDX_W'($urandom());
        dst = IDX_W'($urandom());
      end
      send_item(op, src, dst);
    end
  endtask

  // Drop valid and wait until every outstanding result has been taken.
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_node_count(logic [NUM_W-1:0] value);
    drain();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // Result sink: random stalls, plus a long hold-off whenever one is asked for.
  initial begin : result_sink
    int stall_left;
    stall_left    = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_taken != holds_asked) begin
        holds_taken++;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && rx_idling && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Run limit, well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.op        = OP_ADD;
    in_bus.node_from = '0;
    in_bus.node_to   = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.data     = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unused op, clear on empty, reverse edges, repeats, self-loops.
    rx_idling = 1'b1;
    write_node_count(7'd64);
    send_item(OP_UNUSED, 6'd0, 6'd0);
    send_item(OP_CLEAR, 6'd0, 6'd0);
    send_item(OP_ADD, 6'd0, 6'd63);
    send_item(OP_ADD, 6'd63, 6'd0);
    send_item(OP_ADD, 6'd63, 6'd63);
    send_item(OP_ADD, 6'd0, 6'd63);
    send_item(OP_REMOVE, 6'd5, 6'd6);
    send_item(OP_ADD, 6'd0, 6'd0);
    send_item(OP_UNUSED, 6'd63, 6'd0);
    send_item(OP_REMOVE, 6'd63, 6'd0);
    send_item(OP_REMOVE, 6'd0, 6'd63);
    send_item(OP_REMOVE, 6'd63, 6'd63);
    send_item(OP_ADD, 6'd1, 6'd2);
    send_item(OP_ADD, 6'd2, 6'd1);
    send_item(OP_ADD, 6'd42, 6'd21);
    send_item(OP_ADD, 6'd21, 6'd42);

    // Shrink the node count: out-of-range indices, stored edges left behind.
    write_node_count(7'd10);
    send_item(OP_ADD, 6'd10, 6'd3);
    send_item(OP_REMOVE, 6'd3, 6'd63);
    send_item(OP_REMOVE, 6'd42, 6'd21);
    send_item(OP_ADD, 6'd2, 6'd1);
    send_item(OP_UNUSED, 6'd63, 6'd1);
    send_item(OP_CLEAR, 6'd12, 6'd40);
    send_item(OP_CLEAR, 6'd0, 6'd0);

    // Dense small graph with idling on both sides.
    write_node_count(7'd64);
    tx_idling = 1'b1;
    send_random(280, 8);

    // Shrink again with no idling anywhere.
    write_node_count(7'd5);
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    send_random(160, 6);

    // Fan-out and fan-in to full degree; hold off results while items keep coming.
    write_node_count(7'd64);
    rx_idling = 1'b1;
    for (int k = 0; k < MAX_NODES; k++) send_item(OP_ADD, 6'd3, IDX_W'(k));
    holds_asked++;
    for (int k = 0; k < MAX_NODES; k++) send_item(OP_ADD, IDX_W'(k), 6'd9);
    tx_idling = 1'b1;
    send_random(150, 64);

    // Node count above the maximum saturates.
    write_node_count(7'd127);
    send_random(220, 16);

    // Tiny and empty node ranges.
    write_node_count(7'd1);
    send_random(60, 2);
    write_node_count(7'd0);
    send_random(30, 4);
    write_node_count(7'd2);
    send_random(50, 3);

    // Medium range with a second long hold-off at the start.
    write_node_count(7'd20);
    tx_idling = 1'b0;
    holds_asked++;
    send_random(40, 24);
    tx_idling = 1'b1;
    send_random(220, 24);

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule : graph_adjacency_edge_store_test
